// ----- hw/rtl/dmm_pkg.sv -----
`default_nettype none

package dmm_pkg;

	localparam int DIM_W     = 4;
	localparam int POS_W     = 3;
	localparam int ACC_W     = 40;
	localparam int ACT_W     = 2;
	localparam int CFG_IDX_W = 2;
	localparam int STEP_W    = 3;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [DIM_W-1:0]  dim_t;

	// item actions
	localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_OF_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_OF_B    = 2'd2;

	localparam dim_t DIM_RESET = 4'd8;

	// microprogram steps
	localparam step_t ST_IDLE   = 3'd0;
	localparam step_t ST_ELEM   = 3'd1;
	localparam step_t ST_READ   = 3'd2;
	localparam step_t ST_DRAIN1 = 3'd3;
	localparam step_t ST_DRAIN2 = 3'd4;
	localparam step_t ST_EMIT   = 3'd5;
	localparam step_t ST_LOOP   = 3'd6;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_COMPUTE,
		COND_K_MORE,
		COND_OUT_BUSY,
		COND_ELEM_MORE
	} cond_t;

	typedef struct packed {
		logic  in_ready;
		logic  clr_ij;
		logic  clr_k;
		logic  rd_en;
		logic  emit;
		logic  inc_ij;
		cond_t cond;
		step_t t_true;
		step_t t_false;
	} ctrl_word_t;

	typedef struct packed {
		logic compute_req;
		logic k_more;
		logic out_busy;
		logic elem_more;
	} dp_status_t;

	function automatic ctrl_word_t ucode_rom(input step_t s);
		ctrl_word_t w;
		w = '0;
		w.cond    = COND_ALWAYS;
		w.t_true  = ST_IDLE;
		w.t_false = ST_IDLE;
		case (s)
			ST_IDLE: begin
				w.in_ready = 1'b1;
				w.clr_ij   = 1'b1;
				w.cond     = COND_COMPUTE;
				w.t_true   = ST_ELEM;
				w.t_false  = ST_IDLE;
			end
			ST_ELEM: begin
				w.clr_k  = 1'b1;
				w.t_true = ST_READ;
			end
			ST_READ: begin
				w.rd_en   = 1'b1;
				w.cond    = COND_K_MORE;
				w.t_true  = ST_READ;
				w.t_false = ST_DRAIN1;
			end
			ST_DRAIN1: begin
				w.t_true = ST_DRAIN2;
			end
			ST_DRAIN2: begin
				w.t_true = ST_EMIT;
			end
			ST_EMIT: begin
				w.emit    = 1'b1;
				w.cond    = COND_OUT_BUSY;
				w.t_true  = ST_EMIT;
				w.t_false = ST_LOOP;
			end
			ST_LOOP: begin
				w.inc_ij  = 1'b1;
				w.cond    = COND_ELEM_MORE;
				w.t_true  = ST_ELEM;
				w.t_false = ST_IDLE;
			end
			default: begin
				w.t_true = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dmm_ram.sv -----
`default_nettype none

module dmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                                       clk,
	input  wire logic                                       wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                           wr_data,
	input  wire logic                                       rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output      logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dmm_sequencer.sv -----
`default_nettype none

module dmm_sequencer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dmm_pkg::dp_status_t status,
	output      dmm_pkg::ctrl_word_t ctrl
);

	dmm_pkg::step_t step_q;
	dmm_pkg::step_t step_d;
	logic           taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= dmm_pkg::ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctrl = dmm_pkg::ucode_rom(step_q);
		case (ctrl.cond)
			dmm_pkg::COND_ALWAYS:    taken = 1'b1;
			dmm_pkg::COND_COMPUTE:   taken = status.compute_req;
			dmm_pkg::COND_K_MORE:    taken = status.k_more;
			dmm_pkg::COND_OUT_BUSY:  taken = status.out_busy;
			dmm_pkg::COND_ELEM_MORE: taken = status.elem_more;
			default:                 taken = 1'b1;
		endcase
		step_d = taken ? ctrl.t_true : ctrl.t_false;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dmm_datapath.sv -----
`default_nettype none

module dmm_datapath #(
	parameter int MAX_DIM   = 8,
	parameter int ELEM_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire dmm_pkg::ctrl_word_t                ctrl,
	output      dmm_pkg::dp_status_t                status,
	input  wire logic                               in_valid,
	input  wire logic [dmm_pkg::ACT_W-1:0]          action,
	input  wire logic [dmm_pkg::POS_W-1:0]          row,
	input  wire logic [dmm_pkg::POS_W-1:0]          col,
	input  wire logic signed [ELEM_BITS-1:0]        value,
	input  wire dmm_pkg::pos_t                      m_last,
	input  wire dmm_pkg::pos_t                      k_last,
	input  wire dmm_pkg::pos_t                      n_last,
	output      logic                               out_valid,
	input  wire logic                               out_ready,
	output      logic [dmm_pkg::POS_W-1:0]          out_row,
	output      logic [dmm_pkg::POS_W-1:0]          out_col,
	output      logic signed [dmm_pkg::ACC_W-1:0]   product_value,
	output      logic                               last
);

	localparam int Depth = MAX_DIM * MAX_DIM;
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int PosW  = dmm_pkg::POS_W;
	localparam int AccW  = dmm_pkg::ACC_W;
	localparam int ProdW = 2 * ELEM_BITS;
	localparam logic [PosW:0] MaxDimP = (PosW + 1)'(MAX_DIM);

	dmm_pkg::pos_t i_q, j_q, k_q;

	logic [AddrW-1:0] wr_addr, a_rd_addr, b_rd_addr;
	logic             in_range, accept, a_wr, b_wr, emit_load;

	logic signed [ELEM_BITS-1:0] a_rd_s1, b_rd_s1;
	logic                        rd_v_s1;
	logic signed [ProdW-1:0]     prod_s2;
	logic                        prod_v_s2;
	logic signed [AccW-1:0]      acc_q;

	logic                   out_valid_q;
	dmm_pkg::pos_t          out_row_q, out_col_q;
	logic signed [AccW-1:0] out_value_q;
	logic                   out_last_q;

	assign accept   = in_valid & ctrl.in_ready;
	assign in_range = ({1'b0, row} < MaxDimP) && ({1'b0, col} < MaxDimP);
	assign a_wr     = accept && in_range && (action == dmm_pkg::ACT_LOAD_A);
	assign b_wr     = accept && in_range && (action == dmm_pkg::ACT_LOAD_B);

	assign wr_addr   = AddrW'(32'(row) * MAX_DIM + 32'(col));
	assign a_rd_addr = AddrW'(32'(i_q) * MAX_DIM + 32'(k_q));
	assign b_rd_addr = AddrW'(32'(k_q) * MAX_DIM + 32'(j_q));

	dmm_ram #(
		.WIDTH(ELEM_BITS),
		.DEPTH(Depth)
	) u_a_ram (
		.clk     (clk),
		.wr_en   (a_wr),
		.wr_addr (wr_addr),
		.wr_data (value),
		.rd_en   (ctrl.rd_en),
		.rd_addr (a_rd_addr),
		.rd_data (a_rd_s1)
	);

	dmm_ram #(
		.WIDTH(ELEM_BITS),
		.DEPTH(Depth)
	) u_b_ram (
		.clk     (clk),
		.wr_en   (b_wr),
		.wr_addr (wr_addr),
		.wr_data (value),
		.rd_en   (ctrl.rd_en),
		.rd_addr (b_rd_addr),
		.rd_data (b_rd_s1)
	);

	always_comb begin
		status.compute_req = accept && (action == dmm_pkg::ACT_COMPUTE);
		status.k_more      = (k_q != k_last);
		status.out_busy    = out_valid_q & ~out_ready;
		status.elem_more   = !((i_q == m_last) && (j_q == n_last));
	end

	assign emit_load = ctrl.emit & ~status.out_busy;

	// loop indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (ctrl.clr_ij) begin
				i_q <= '0;
				j_q <= '0;
			end else if (ctrl.inc_ij) begin
				if (j_q == n_last) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (ctrl.clr_k) begin
				k_q <= '0;
			end else if (ctrl.rd_en) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// multiply-accumulate pipe: read, multiply, add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1   <= 1'b0;
			prod_v_s2 <= 1'b0;
		end else begin
			rd_v_s1   <= ctrl.rd_en;
			prod_v_s2 <= rd_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			prod_s2 <= a_rd_s1 * b_rd_s1;
		end
		if (ctrl.clr_k) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + AccW'(prod_s2);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_row_q   <= i_q;
			out_col_q   <= j_q;
			out_value_q <= acc_q;
			out_last_q  <= (i_q == m_last) && (j_q == n_last);
		end
	end

	assign out_valid     = out_valid_q;
	assign out_row       = out_row_q;
	assign out_col       = out_col_q;
	assign product_value = out_value_q;
	assign last          = out_last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dense_matrix_multiply_core.sv -----
// Dense matrix multiply C = A * B on signed Q8.8 elements, Q24.16 results.
// Input channel (in_valid/in_ready): action selects load A, load B or compute.
// A load item writes value at (row, col) of the chosen store and
// gives no result; a row or col at or above MAX_DIM is dropped.
// A compute item emits rows_of_a * cols_of_b result items in row-major order,
// last set on the final one. Each element runs through the microprogram:
// a start step, one read per k from the A and B RAMs, a multiply and an add
// stage to drain, an emit step and a loop step. The block takes no new item
// until the whole matrix has been handed to the output register.
// Output channel (out_valid/out_ready): a single output register; when the
// receiver stalls the sequencer waits in its emit step and holds the result.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 rows_of_a,
// 1 inner_length, 2 cols_of_b; 0 acts as 1, values above MAX_DIM as MAX_DIM.
// Reset sets all three sizes to 8 and empties the output register; store
// contents are undefined until loaded.
`default_nettype none

module dense_matrix_multiply_core #(
	parameter int MAX_DIM   = 8,
	parameter int ELEM_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output      logic                                  in_ready,
	input  wire logic [dmm_pkg::ACT_W-1:0]             action,
	input  wire logic [dmm_pkg::POS_W-1:0]             row,
	input  wire logic [dmm_pkg::POS_W-1:0]             col,
	input  wire logic signed [ELEM_BITS-1:0]           value,
	output      logic                                  out_valid,
	input  wire logic                                  out_ready,
	output      logic [dmm_pkg::POS_W-1:0]             out_row,
	output      logic [dmm_pkg::POS_W-1:0]             out_col,
	output      logic signed [dmm_pkg::ACC_W-1:0]      product_value,
	output      logic                                  last,
	input  wire logic                                  cfg_valid,
	output      logic                                  cfg_ready,
	input  wire logic [dmm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [dmm_pkg::DIM_W-1:0]             cfg_data
);

	localparam int DimW = dmm_pkg::DIM_W;
	localparam int PosW = dmm_pkg::POS_W;
	localparam dmm_pkg::dim_t MaxDimD = DimW'(MAX_DIM);

	dmm_pkg::dim_t       rows_q, inner_q, cols_q;
	dmm_pkg::pos_t       m_last, k_last, n_last;
	dmm_pkg::ctrl_word_t ctrl;
	dmm_pkg::dp_status_t status;

	// saturate a size to 1..MAX_DIM and return its last index
	function automatic dmm_pkg::pos_t dim_last(input dmm_pkg::dim_t d);
		dmm_pkg::pos_t r;
		if (d == '0) begin
			r = '0;
		end else if (d > MaxDimD) begin
			r = PosW'(MaxDimD - 1'b1);
		end else begin
			r = PosW'(d - 1'b1);
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= dmm_pkg::DIM_RESET;
			inner_q <= dmm_pkg::DIM_RESET;
			cols_q  <= dmm_pkg::DIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				dmm_pkg::REG_ROWS_OF_A:    rows_q  <= cfg_data;
				dmm_pkg::REG_INNER_LENGTH: inner_q <= cfg_data;
				dmm_pkg::REG_COLS_OF_B:    cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		m_last = dim_last(rows_q);
		k_last = dim_last(inner_q);
		n_last = dim_last(cols_q);
	end

	assign in_ready = ctrl.in_ready;

	dmm_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	dmm_datapath #(
		.MAX_DIM   (MAX_DIM),
		.ELEM_BITS (ELEM_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.status        (status),
		.in_valid      (in_valid),
		.action        (action),
		.row           (row),
		.col           (col),
		.value         (value),
		.m_last        (m_last),
		.k_last        (k_last),
		.n_last        (n_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_row       (out_row),
		.out_col       (out_col),
		.product_value (product_value),
		.last          (last)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/dmm_checker.sv -----
`default_nettype none

module dmm_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic [dmm_pkg::ACT_W-1:0]      action,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [dmm_pkg::POS_W-1:0]      out_row,
	input wire logic [dmm_pkg::POS_W-1:0]      out_col,
	input wire logic [dmm_pkg::ACC_W-1:0]      product_value,
	input wire logic                           last
);

	// a compute item closes the input side at once
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && action == dmm_pkg::ACT_COMPUTE) |=> !in_ready)
		else $error("input still ready after compute item");

	// while a non-final element waits, the matrix is still being worked
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> !in_ready)
		else $error("input ready in the middle of a result matrix");

	// with the input side open nothing is being formed, so a taken result empties the output
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && in_ready) |=> !out_valid)
		else $error("result item while the sequencer is idle");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(out_row) && $stable(out_col)
			 && $stable(product_value) && $stable(last)))
		else $error("stalled result item changed");

endmodule

bind dense_matrix_multiply_core dmm_checker u_dmm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.action        (action),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_row       (out_row),
	.out_col       (out_col),
	.product_value (product_value),
	.last          (last)
);

`default_nettype wire

// ----- tb/matrix_product_checker.sv -----
module matrix_product_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic [dmm_pkg::ACT_W-1:0]            action,
	input  dmm_pkg::pos_t                        row,
	input  dmm_pkg::pos_t                        col,
	input  logic signed [15:0]                   value,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  dmm_pkg::pos_t                        out_row,
	input  dmm_pkg::pos_t                        out_col,
	input  logic signed [dmm_pkg::ACC_W-1:0]     product_value,
	input  logic                                 last,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [dmm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  dmm_pkg::dim_t                        cfg_data,
	output int                                   pending,
	output int                                   fail_count
);
	import dmm_pkg::*;

	localparam int MAX_DIM = 8;

	typedef struct {
		pos_t                    r;
		pos_t                    c;
		logic signed [ACC_W-1:0] sum;
		logic                    is_last;
	} c_elem_t;

	logic signed [15:0] a_elems [MAX_DIM][MAX_DIM];
	logic signed [15:0] b_elems [MAX_DIM][MAX_DIM];
	dim_t               m_size;
	dim_t               p_size;
	dim_t               n_size;
	c_elem_t            expected_elems [$];
	int                 errors = 0;

	assign fail_count = errors;

	function automatic int unsigned clamp_dim(input dim_t d);
		if (d == 0)
			return 1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return d;
	endfunction

	// queue every element of C in row-major order
	function automatic void predict_product();
		int unsigned             m;
		int unsigned             p;
		int unsigned             n;
		logic signed [ACC_W-1:0] acc;
		c_elem_t                 e;
		m = clamp_dim(m_size);
		p = clamp_dim(p_size);
		n = clamp_dim(n_size);
		for (int i = 0; i < m; i++) begin
			for (int j = 0; j < n; j++) begin
				acc = '0;
				for (int k = 0; k < p; k++)
					acc = acc + a_elems[i][k] * b_elems[k][j];
				e.r       = pos_t'(i);
				e.c       = pos_t'(j);
				e.sum     = acc;
				e.is_last = (i == m - 1) && (j == n - 1);
				expected_elems.push_back(e);
			end
		end
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : check_proc
		c_elem_t head;
		if (!arst_n) begin
			m_size = DIM_RESET;
			p_size = DIM_RESET;
			n_size = DIM_RESET;
			expected_elems.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROWS_OF_A:    m_size = cfg_data;
					REG_INNER_LENGTH: p_size = cfg_data;
					REG_COLS_OF_B:    n_size = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_elems.size() == 0) begin
					report_mismatch($sformatf("element (%0d,%0d) value %0d with nothing expected",
						out_row, out_col, product_value));
				end else begin
					head = expected_elems.pop_front();
					if (out_row !== head.r)
						report_mismatch($sformatf("out_row %0d, expected %0d", out_row, head.r));
					if (out_col !== head.c)
						report_mismatch($sformatf("out_col %0d, expected %0d", out_col, head.c));
					if (product_value !== head.sum)
						report_mismatch($sformatf("product_value %0d at (%0d,%0d), expected %0d",
							product_value, head.r, head.c, head.sum));
					if (last !== head.is_last)
						report_mismatch($sformatf("last %b at (%0d,%0d), expected %b",
							last, head.r, head.c, head.is_last));
				end
			end
			if (in_valid && in_ready) begin
				case (action)
					ACT_LOAD_A:  a_elems[row][col] = value;
					ACT_LOAD_B:  b_elems[row][col] = value;
					ACT_COMPUTE: predict_product();
					default: ;
				endcase
			end
			pending <= expected_elems.size();
		end
	end

endmodule

// ----- tb/tb_dense_matrix_multiply_core.sv -----
module tb_dense_matrix_multiply_core;
	import dmm_pkg::*;

	localparam int N_ITEMS     = 180;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 16;

	// codes the block has no use for
	localparam logic [ACT_W-1:0]     ACT_IGNORED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [ACT_W-1:0]        action = '0;
	pos_t                    row = '0;
	pos_t                    col = '0;
	logic signed [15:0]      value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	pos_t                    out_row;
	pos_t                    out_col;
	logic signed [ACC_W-1:0] product_value;
	logic                    last;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	dim_t                    cfg_data = '0;
	int                      pending;
	int                      fail_count;

	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	logic        hold_req = 1'b0;
	logic        hold_done = 1'b0;
	bit          a_loaded [8][8];
	bit          b_loaded [8][8];
	int unsigned cur_m = 8;
	int unsigned cur_p = 8;
	int unsigned cur_n = 8;
	int          items_sent = 0;
	int          quiet_cycles = 0;

	always #5 clk = ~clk;

	dense_matrix_multiply_core DUT (.*);

	matrix_product_checker product_check (.*);

	function automatic int unsigned clamp_size(input dim_t d);
		if (d == 0)
			return 1;
		if (d > 8)
			return 8;
		return d;
	endfunction

	function automatic logic signed [15:0] rand_elem();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic dim_t rand_size();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return 4'd0;
		if (pick < 20)
			return dim_t'($urandom_range(15, 8));
		return dim_t'($urandom_range(4, 1));
	endfunction

	// hold valid and payload until the item is taken
	task automatic send_item(input logic [ACT_W-1:0] act, input pos_t r, input pos_t c,
		input logic signed [15:0] v);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		row      <= r;
		col      <= c;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		if (act == ACT_LOAD_A)
			a_loaded[r][c] = 1'b1;
		else if (act == ACT_LOAD_B)
			b_loaded[r][c] = 1'b1;
		if (act != ACT_IGNORED)
			items_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input dim_t d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_sizes(input dim_t m, input dim_t p, input dim_t n,
		input bit poke_unused = 1'b0);
		wait_drained();
		if (poke_unused)
			write_reg(REG_UNUSED, 4'd5);
		write_reg(REG_ROWS_OF_A, m);
		write_reg(REG_INNER_LENGTH, p);
		write_reg(REG_COLS_OF_B, n);
		cfg_valid <= 1'b0;
		cur_m = clamp_size(m);
		cur_p = clamp_size(p);
		cur_n = clamp_size(n);
	endtask

	// fill every entry the next compute reads that has never been written
	task automatic load_missing();
		for (int i = 0; i < cur_m; i++)
			for (int k = 0; k < cur_p; k++)
				if (!a_loaded[i][k])
					send_item(ACT_LOAD_A, pos_t'(i), pos_t'(k), rand_elem());
		for (int k = 0; k < cur_p; k++)
			for (int j = 0; j < cur_n; j++)
				if (!b_loaded[k][j])
					send_item(ACT_LOAD_B, pos_t'(k), pos_t'(j), rand_elem());
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int job;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single element: most negative squared, then mixed extremes
		set_sizes(4'd0, 4'd1, 4'd1, 1'b1);
		send_item(ACT_LOAD_A, 3'd0, 3'd0, 16'h8000);
		send_item(ACT_LOAD_B, 3'd0, 3'd0, 16'h8000);
		send_item(ACT_COMPUTE, 3'd0, 3'd0, 16'h0000);
		send_item(ACT_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
		send_item(ACT_COMPUTE, 3'd7, 3'd7, 16'hFFFF);
		send_item(ACT_IGNORED, 3'd7, 3'd7, 16'hFFFF);

		// a tall column of A, rows saturate to the maximum
		set_sizes(4'd15, 4'd1, 4'd1);
		for (int i = 1; i < 8; i++)
			send_item(ACT_LOAD_A, pos_t'(i), 3'd0, (i % 2) ? 16'h8000 : 16'h7FFF);
		send_item(ACT_COMPUTE, 3'd0, 3'd0, 16'h0000);

		// a wide row of B, columns saturate as well
		set_sizes(4'd1, 4'd1, 4'd9);
		for (int j = 1; j < 8; j++)
			send_item(ACT_LOAD_B, 3'd0, pos_t'(j), (j % 2) ? 16'h7FFF : 16'h8000);
		send_item(ACT_COMPUTE, 3'd0, 3'd0, 16'h0000);

		items_sent = 0;
		job = 0;
		while (items_sent < N_ITEMS) begin
			case (items_sent * 4 / N_ITEMS)
				0: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct  = 77;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 77;
				end
				default: begin
					tx_idle_pct  = 27;
					rx_stall_pct = 27;
				end
			endcase
			// keep the sizes over the first jobs so the hold-off backs up a full matrix
			if (job == 0)
				set_sizes(4'd4, 4'd3, 4'd4);
			else if (job > 2 && $urandom_range(2) == 0)
				set_sizes(rand_size(), rand_size(), rand_size());
			repeat ($urandom_range(4))
				send_item($urandom_range(1) ? ACT_LOAD_B : ACT_LOAD_A, pos_t'($urandom),
					pos_t'($urandom), rand_elem());
			if ($urandom_range(9) == 0)
				send_item(ACT_IGNORED, pos_t'($urandom), pos_t'($urandom), 16'($urandom));
			load_missing();
			if (job == 1)
				hold_req = 1'b1;
			send_item(ACT_COMPUTE, pos_t'($urandom), pos_t'($urandom), 16'($urandom));
			job++;
		end

		wait_drained();
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
